// File: rtl/core/sepl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sepl_pkg;

  localparam int SLOTS_PER_TURN = 180;
  localparam int DUTY_BITS      = 12;

  localparam int FULL_PCT   = 100;
  localparam int Q_FRAC     = 16;
  localparam int DEG_FULL   = 360 << Q_FRAC;
  localparam int FULL_SCALE = FULL_PCT << Q_FRAC;
  localparam int DUTY_MAX   = (1 << DUTY_BITS) - 1;

  localparam int REF_W   = 26;
  localparam int GAIN_W  = 24;
  localparam int DEB_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ANG_W   = 25;
  localparam int ERR_W   = 32;
  localparam int SLOT_W  = 8;
  localparam int REM_W   = SLOT_W + 1;
  localparam int STEP_Q  = DEG_FULL / SLOTS_PER_TURN;
  localparam int STEP_R  = DEG_FULL % SLOTS_PER_TURN;

  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W - Q_FRAC;
  localparam int SUM_W   = ERR_W + 2;
  localparam int CLAMP_W = $clog2(FULL_SCALE + 1);

  // floor(y / 100) = (y * RECIP) >> RECIP_SH, exact for y below 2^30
  localparam int      RECIP_SH = 32;
  localparam longint  RECIP    = ((longint'(1) <<< RECIP_SH) + FULL_PCT - 1) / FULL_PCT;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam int IN_RAW_W    = 1 + TIME_W;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = DUTY_BITS + ANG_W + ERR_W + ERR_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int PC_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_ANGLE,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_FILTER_COEF,
    REG_MIN_GAP_US,
    REG_COUNT_FALLING
  } cfg_reg_t;

  typedef enum logic [2:0] {MA_GP, MA_GI, MA_GD, MA_FC, MA_DMAX, MA_RECIP} mula_sel_t;
  typedef enum logic [2:0] {MB_ERR, MB_PREV, MB_DER, MB_CTRL, MB_Y} mulb_sel_t;
  typedef enum logic [2:0] {ACC_NOP, ACC_Q, ACC_QINT, ACC_QDER, ACC_SUBQ} acc_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_UP, WR_UI, WR_UD} wr_op_t;
  typedef enum logic {BR_NEXT, BR_END} br_t;

  typedef struct packed {
    logic      mul_en;
    mula_sel_t mula;
    mulb_sel_t mulb;
    acc_op_t   acc;
    wr_op_t    wr;
    logic      err_ld;
    logic      ctrl_ld;
    logic      out_ld;
    br_t       br;
  } uword_t;

  localparam uword_t UC_NOP = '{
    mul_en: 1'b0, mula: MA_GP, mulb: MB_ERR, acc: ACC_NOP, wr: WR_NONE,
    err_ld: 1'b0, ctrl_ld: 1'b0, out_ld: 1'b0, br: BR_NEXT
  };

  localparam logic [PC_W-1:0] ST_ERR    = 4'd0;
  localparam logic [PC_W-1:0] ST_MP     = 4'd1;
  localparam logic [PC_W-1:0] ST_MI     = 4'd2;
  localparam logic [PC_W-1:0] ST_MDE    = 4'd3;
  localparam logic [PC_W-1:0] ST_MDP    = 4'd4;
  localparam logic [PC_W-1:0] ST_MFC    = 4'd5;
  localparam logic [PC_W-1:0] ST_SUBFC  = 4'd6;
  localparam logic [PC_W-1:0] ST_WRD    = 4'd7;
  localparam logic [PC_W-1:0] ST_CTRL   = 4'd8;
  localparam logic [PC_W-1:0] ST_MDUTY  = 4'd9;
  localparam logic [PC_W-1:0] ST_MRECIP = 4'd10;
  localparam logic [PC_W-1:0] ST_OUT    = 4'd11;

  function automatic logic signed [ERR_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic fits;
    fits = (&x[ACC_W-1:ERR_W-1]) | ~(|x[ACC_W-1:ERR_W-1]);
    if (fits) begin
      return x[ERR_W-1:0];
    end else if (x[ACC_W-1]) begin
      return {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ERR_W-1){1'b1}}};
    end
  endfunction

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UC_NOP;
    unique case (pc)
      ST_ERR: begin
        w.err_ld = 1'b1;
      end
      ST_MP: begin
        w.mul_en = 1'b1; w.mula = MA_GP; w.mulb = MB_ERR;
      end
      ST_MI: begin
        w.mul_en = 1'b1; w.mula = MA_GI; w.mulb = MB_PREV; w.acc = ACC_Q;
      end
      ST_MDE: begin
        w.mul_en = 1'b1; w.mula = MA_GD; w.mulb = MB_ERR;
        w.acc = ACC_QINT; w.wr = WR_UP;
      end
      ST_MDP: begin
        w.mul_en = 1'b1; w.mula = MA_GD; w.mulb = MB_PREV;
        w.acc = ACC_QDER; w.wr = WR_UI;
      end
      ST_MFC: begin
        w.mul_en = 1'b1; w.mula = MA_FC; w.mulb = MB_DER; w.acc = ACC_SUBQ;
      end
      ST_SUBFC: begin
        w.acc = ACC_SUBQ;
      end
      ST_WRD: begin
        w.wr = WR_UD;
      end
      ST_CTRL: begin
        w.ctrl_ld = 1'b1;
      end
      ST_MDUTY: begin
        w.mul_en = 1'b1; w.mula = MA_DMAX; w.mulb = MB_CTRL;
      end
      ST_MRECIP: begin
        w.mul_en = 1'b1; w.mula = MA_RECIP; w.mulb = MB_Y;
      end
      ST_OUT: begin
        w.out_ld = 1'b1; w.br = BR_END;
      end
      default: begin
        w.br = BR_END;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sepl_enc.sv
`timescale 1ns / 1ps
`default_nettype none
module sepl_enc (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               sample_en,
  input  wire logic                               pin_level,
  input  wire logic [sepl_pkg::TIME_W-1:0]        time_us,
  input  wire logic [sepl_pkg::DEB_W-1:0]         min_gap_us,
  input  wire logic                               count_falling,
  output logic      [sepl_pkg::ANG_W-1:0]         slot_angle
);

  logic                            last_pin_r, last_pin_nxt;
  logic [sepl_pkg::TIME_W-1:0]     last_edge_r, last_edge_nxt;
  logic [sepl_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [sepl_pkg::ANG_W-1:0]      ang_q_r, ang_q_nxt;
  logic [sepl_pkg::SLOT_W-1:0]     ang_rem_r, ang_rem_nxt;
  logic [sepl_pkg::TIME_W-1:0]     elapsed;
  logic [sepl_pkg::REM_W-1:0]      rem_sum;
  logic                            count_edge;

  assign elapsed = time_us - last_edge_r;
  assign rem_sum = {1'b0, ang_rem_r} + sepl_pkg::REM_W'(sepl_pkg::STEP_R);
  assign count_edge = sample_en && (pin_level != last_pin_r) && (last_pin_r == count_falling)
                      && (elapsed >= sepl_pkg::TIME_W'(min_gap_us));

  always_comb begin
    last_pin_nxt  = last_pin_r;
    last_edge_nxt = last_edge_r;
    slot_nxt      = slot_r;
    ang_q_nxt     = ang_q_r;
    ang_rem_nxt   = ang_rem_r;
    if (sample_en) begin
      last_pin_nxt = pin_level;
    end
    if (count_edge) begin
      last_edge_nxt = time_us;
      if (slot_r == sepl_pkg::SLOT_W'(sepl_pkg::SLOTS_PER_TURN - 1)) begin
        slot_nxt    = '0;
        ang_q_nxt   = '0;
        ang_rem_nxt = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
        if (rem_sum >= sepl_pkg::REM_W'(sepl_pkg::SLOTS_PER_TURN)) begin
          ang_rem_nxt = sepl_pkg::SLOT_W'(rem_sum - sepl_pkg::REM_W'(sepl_pkg::SLOTS_PER_TURN));
          ang_q_nxt   = ang_q_r + sepl_pkg::ANG_W'(sepl_pkg::STEP_Q + 1);
        end else begin
          ang_rem_nxt = rem_sum[sepl_pkg::SLOT_W-1:0];
          ang_q_nxt   = ang_q_r + sepl_pkg::ANG_W'(sepl_pkg::STEP_Q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pin_r  <= 1'b1;
      last_edge_r <= '0;
      slot_r      <= '0;
      ang_q_r     <= '0;
      ang_rem_r   <= '0;
    end else begin
      last_pin_r  <= last_pin_nxt;
      last_edge_r <= last_edge_nxt;
      slot_r      <= slot_nxt;
      ang_q_r     <= ang_q_nxt;
      ang_rem_r   <= ang_rem_nxt;
    end
  end

  assign slot_angle = ang_q_r;

endmodule
`default_nettype wire

// File: rtl/core/sepl_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module sepl_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             out_hold,
  output logic                  busy,
  output sepl_pkg::uword_t      uc
);

  logic                      busy_r, busy_nxt;
  logic [sepl_pkg::PC_W-1:0] pc_r, pc_nxt;
  sepl_pkg::uword_t          word;
  logic                      at_end;

  assign word   = sepl_pkg::ucode(pc_r);
  assign at_end = (word.br == sepl_pkg::BR_END);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = sepl_pkg::ST_ERR;
      end
    end else if (at_end) begin
      if (!out_hold) begin
        busy_nxt = 1'b0;
      end
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_comb begin
    uc = sepl_pkg::UC_NOP;
    if (busy_r) begin
      uc = word;
      if (at_end && out_hold) begin
        uc.out_ld = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// File: rtl/core/sepl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sepl_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire sepl_pkg::uword_t                         uc,
  input  wire logic signed [sepl_pkg::REF_W-1:0]        ref_angle,
  input  wire logic signed [sepl_pkg::GAIN_W-1:0]       gain_p,
  input  wire logic signed [sepl_pkg::GAIN_W-1:0]       gain_i,
  input  wire logic signed [sepl_pkg::GAIN_W-1:0]       gain_d,
  input  wire logic signed [sepl_pkg::GAIN_W-1:0]       filter_coef,
  input  wire logic        [sepl_pkg::ANG_W-1:0]        slot_angle,
  input  wire logic                                     out_tready,
  output logic                                          out_tvalid,
  output logic             [sepl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                          out_hold
);

  logic        [sepl_pkg::ANG_W-1:0]     held_r;
  logic signed [sepl_pkg::ERR_W-1:0]     err_r;
  logic signed [sepl_pkg::ERR_W-1:0]     prev_r;
  logic signed [sepl_pkg::ERR_W-1:0]     int_r;
  logic signed [sepl_pkg::ERR_W-1:0]     der_r;
  logic signed [sepl_pkg::ERR_W-1:0]     ctrl_r;
  logic signed [sepl_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [sepl_pkg::SUM_W-1:0]     sum_r;
  logic signed [sepl_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [sepl_pkg::MUL_A_W-1:0]   mula_v;
  logic signed [sepl_pkg::MUL_B_W-1:0]   mulb_v;
  logic signed [sepl_pkg::ACC_W-1:0]     q_v;
  logic signed [sepl_pkg::ERR_W-1:0]     sat_acc;
  logic        [sepl_pkg::CLAMP_W-1:0]   clamp_v;
  logic                                  out_valid_r;
  logic        [sepl_pkg::DUTY_BITS-1:0] out_duty_r;
  logic        [sepl_pkg::ANG_W-1:0]     out_ang_r;
  logic        [sepl_pkg::ERR_W-1:0]     out_err_r;
  logic        [sepl_pkg::ERR_W-1:0]     out_ctrl_r;

  assign q_v     = prod_r[sepl_pkg::PROD_W-1:sepl_pkg::Q_FRAC];
  assign sat_acc = sepl_pkg::sat32(acc_r);

  always_comb begin
    if (ctrl_r[sepl_pkg::ERR_W-1]) begin
      clamp_v = '0;
    end else if (ctrl_r[sepl_pkg::ERR_W-2:0] >
                 (sepl_pkg::ERR_W-1)'(sepl_pkg::FULL_SCALE)) begin
      clamp_v = sepl_pkg::CLAMP_W'(sepl_pkg::FULL_SCALE);
    end else begin
      clamp_v = ctrl_r[sepl_pkg::CLAMP_W-1:0];
    end
  end

  always_comb begin
    unique case (uc.mula)
      sepl_pkg::MA_GP:    mula_v = sepl_pkg::MUL_A_W'(gain_p);
      sepl_pkg::MA_GI:    mula_v = sepl_pkg::MUL_A_W'(gain_i);
      sepl_pkg::MA_GD:    mula_v = sepl_pkg::MUL_A_W'(gain_d);
      sepl_pkg::MA_FC:    mula_v = sepl_pkg::MUL_A_W'(filter_coef);
      sepl_pkg::MA_DMAX:  mula_v = sepl_pkg::MUL_A_W'(sepl_pkg::DUTY_MAX);
      sepl_pkg::MA_RECIP: mula_v = sepl_pkg::MUL_A_W'(sepl_pkg::RECIP);
      default:            mula_v = '0;
    endcase
  end

  always_comb begin
    unique case (uc.mulb)
      sepl_pkg::MB_ERR:  mulb_v = sepl_pkg::MUL_B_W'(err_r);
      sepl_pkg::MB_PREV: mulb_v = sepl_pkg::MUL_B_W'(prev_r);
      sepl_pkg::MB_DER:  mulb_v = sepl_pkg::MUL_B_W'(der_r);
      sepl_pkg::MB_CTRL: mulb_v = sepl_pkg::MUL_B_W'(clamp_v);
      sepl_pkg::MB_Y:    mulb_v = prod_r[sepl_pkg::Q_FRAC +: sepl_pkg::MUL_B_W];
      default:           mulb_v = '0;
    endcase
  end

  assign prod_nxt = sepl_pkg::PROD_W'(mula_v) * sepl_pkg::PROD_W'(mulb_v);

  always_comb begin
    unique case (uc.acc)
      sepl_pkg::ACC_NOP:  acc_nxt = acc_r;
      sepl_pkg::ACC_Q:    acc_nxt = q_v;
      sepl_pkg::ACC_QINT: acc_nxt = q_v + sepl_pkg::ACC_W'(int_r);
      sepl_pkg::ACC_QDER: acc_nxt = q_v + sepl_pkg::ACC_W'(der_r);
      sepl_pkg::ACC_SUBQ: acc_nxt = acc_r - q_v;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    unique case (uc.wr)
      sepl_pkg::WR_NONE: sum_r <= sum_r;
      sepl_pkg::WR_UP:   sum_r <= sepl_pkg::SUM_W'(sat_acc);
      sepl_pkg::WR_UI,
      sepl_pkg::WR_UD:   sum_r <= sum_r + sepl_pkg::SUM_W'(sat_acc);
      default:           sum_r <= sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      err_r  <= '0;
      prev_r <= '0;
      int_r  <= '0;
      der_r  <= '0;
      ctrl_r <= '0;
    end else begin
      if (uc.err_ld) begin
        err_r  <= sepl_pkg::ERR_W'(ref_angle) - sepl_pkg::ERR_W'(held_r);
        held_r <= slot_angle;
      end
      if (uc.wr == sepl_pkg::WR_UI) begin
        int_r <= sat_acc;
      end
      if (uc.wr == sepl_pkg::WR_UD) begin
        der_r <= sat_acc;
      end
      if (uc.ctrl_ld) begin
        ctrl_r <= sepl_pkg::sat32(sepl_pkg::ACC_W'(sum_r));
        prev_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uc.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.out_ld) begin
      out_duty_r <= prod_r[sepl_pkg::RECIP_SH +: sepl_pkg::DUTY_BITS];
      out_ang_r  <= held_r;
      out_err_r  <= err_r;
      out_ctrl_r <= ctrl_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_hold   = out_valid_r && !out_tready;
  assign out_tdata  = sepl_pkg::OUT_TDATA_W'({out_ctrl_r, out_err_r, out_ang_r, out_duty_r});

endmodule
`default_nettype wire

// File: rtl/core/slot_encoder_pid_pwm_loop.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake                 payload
// in       in   in_tvalid / in_tready     tuser: op; tdata: pin_level, time_us
// out      out  out_tvalid / out_tready   tdata: pwm_duty, angle, error, control_raw
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A pin sample leaves in_tready high, so the next item can be taken right after it.
// A control tick runs a 12-step microprogram around one shared multiplier,
// so the next item is accepted only once the program has run to its end.
// The last step holds while the previous result still waits at the output.
// Synchronous active-low reset; no clearing pass. cfg_ready stays high.
module slot_encoder_pid_pwm_loop (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [sepl_pkg::IN_TDATA_W-1:0]        in_tdata,  // pin_level, time_us
  input  wire logic                                   in_tuser,  // op
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // pwm_duty, angle, error, control_raw
  output logic      [sepl_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [sepl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [sepl_pkg::CFG_W-1:0]             cfg_data
);

  logic signed [sepl_pkg::REF_W-1:0]  ref_angle_r;
  logic signed [sepl_pkg::GAIN_W-1:0] gain_p_r;
  logic signed [sepl_pkg::GAIN_W-1:0] gain_i_r;
  logic signed [sepl_pkg::GAIN_W-1:0] gain_d_r;
  logic signed [sepl_pkg::GAIN_W-1:0] filter_coef_r;
  logic        [sepl_pkg::DEB_W-1:0]  min_gap_us_r;
  logic                               count_falling_r;

  logic                               in_fire;
  logic                               busy;
  logic                               out_hold;
  logic        [sepl_pkg::ANG_W-1:0]  slot_angle;
  sepl_pkg::uword_t                   uc;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_angle_r     <= sepl_pkg::REF_W'(1966080);
      gain_p_r        <= sepl_pkg::GAIN_W'(32768);
      gain_i_r        <= sepl_pkg::GAIN_W'(66);
      gain_d_r        <= sepl_pkg::GAIN_W'(32768);
      filter_coef_r   <= sepl_pkg::GAIN_W'(6554);
      min_gap_us_r    <= sepl_pkg::DEB_W'(800);
      count_falling_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sepl_pkg::cfg_reg_t'(cfg_index))
        sepl_pkg::REG_REF_ANGLE:     ref_angle_r     <= cfg_data[sepl_pkg::REF_W-1:0];
        sepl_pkg::REG_GAIN_P:        gain_p_r        <= cfg_data[sepl_pkg::GAIN_W-1:0];
        sepl_pkg::REG_GAIN_I:        gain_i_r        <= cfg_data[sepl_pkg::GAIN_W-1:0];
        sepl_pkg::REG_GAIN_D:        gain_d_r        <= cfg_data[sepl_pkg::GAIN_W-1:0];
        sepl_pkg::REG_FILTER_COEF:   filter_coef_r   <= cfg_data[sepl_pkg::GAIN_W-1:0];
        sepl_pkg::REG_MIN_GAP_US:    min_gap_us_r    <= cfg_data[sepl_pkg::DEB_W-1:0];
        sepl_pkg::REG_COUNT_FALLING: count_falling_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sepl_enc u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_en     (in_fire && !in_tuser),
    .pin_level     (in_tdata[0]),
    .time_us       (in_tdata[sepl_pkg::TIME_W:1]),
    .min_gap_us    (min_gap_us_r),
    .count_falling (count_falling_r),
    .slot_angle    (slot_angle)
  );

  sepl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && in_tuser),
    .out_hold (out_hold),
    .busy     (busy),
    .uc       (uc)
  );

  sepl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .uc          (uc),
    .ref_angle   (ref_angle_r),
    .gain_p      (gain_p_r),
    .gain_i      (gain_i_r),
    .gain_d      (gain_d_r),
    .filter_coef (filter_coef_r),
    .slot_angle  (slot_angle),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_hold    (out_hold)
  );

endmodule
`default_nettype wire
